/* src/satl_pkg.sv */
// Package of the set-associative tag store: sizes, types and mode codes.
package satl_pkg;
  localparam int SET_COUNT = 64;
  localparam int WAY_COUNT = 4;
  localparam int OFFSET_BITS = 6;
  localparam int INDEX_BITS = $clog2(SET_COUNT);
  localparam int TAG_BITS = 32 - OFFSET_BITS - INDEX_BITS;
  localparam int RANK_BITS = $clog2(WAY_COUNT);
  localparam int ENTRY_BITS = 1 + TAG_BITS + RANK_BITS;
  localparam int ROW_BITS = WAY_COUNT * ENTRY_BITS;
  localparam logic [RANK_BITS-1:0] RANK_OLD = RANK_BITS'(WAY_COUNT - 1);

  typedef enum logic [2:0] {
    MODE_PROBE = 3'd0,
    MODE_TOUCH = 3'd1,
    MODE_WRITE_HIT = 3'd2,
    MODE_INSTALL = 3'd3,
    MODE_EVICT = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [31:0] address;
    logic [1:0] way_sel;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [1:0] way_out;
    logic replaced;
    logic evicted;
    logic [31:0] evicted_address;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic [TAG_BITS-1:0] tag;
    logic [RANK_BITS-1:0] rank;
  } entry_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic compute;
    logic clear;
    logic [INDEX_BITS-1:0] clear_index;
  } ctl_t;
endpackage

/* src/satl_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module satl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/satl_datapath.sv */
// Datapath: set memory, way search, LRU rank update and result register.
module satl_datapath (
  input  logic            clk,
  input  satl_pkg::ctl_t  ctl,
  input  satl_pkg::req_t  req,
  output satl_pkg::rsp_t  rsp
);
  import satl_pkg::*;

  req_t cur;
  logic [ROW_BITS-1:0] rdata;
  logic [ROW_BITS-1:0] wdata;
  logic [ROW_BITS-1:0] row_new;
  logic [INDEX_BITS-1:0] set_idx;
  logic [INDEX_BITS-1:0] waddr;
  logic [TAG_BITS-1:0] tag;
  logic we;
  entry_t ent [WAY_COUNT];
  entry_t nent [WAY_COUNT];
  rsp_t res;

  assign set_idx = cur.address[OFFSET_BITS +: INDEX_BITS];
  assign tag = cur.address[31 -: TAG_BITS];

  // Hold the accepted transaction.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur <= req;
    end
  end

  assign we = ctl.clear | ctl.compute;
  assign waddr = ctl.clear ? ctl.clear_index : set_idx;
  assign wdata = ctl.clear ? {WAY_COUNT{1'b0, TAG_BITS'(0), RANK_OLD}} : row_new;

  satl_ram #(.WIDTH(ROW_BITS), .DEPTH(SET_COUNT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(ctl.read), .raddr(req.address[OFFSET_BITS +: INDEX_BITS]), .rdata(rdata)
  );

  // Decide the result and the new row from the set read.
  always_comb begin
    logic found;
    logic [RANK_BITS-1:0] pway;
    logic [RANK_BITS-1:0] r;
    logic do_promote;
    logic [RANK_BITS-1:0] best;
    logic have_inv;
    logic [RANK_BITS-1:0] sel;
    logic way_ok;
    for (int j = 0; j < WAY_COUNT; j++) begin
      ent[j] = rdata[j*ENTRY_BITS +: ENTRY_BITS];
      nent[j] = ent[j];
    end
    res = '0;
    found = 1'b0;
    pway = '0;
    r = '0;
    do_promote = 1'b0;
    best = '0;
    have_inv = 1'b0;
    way_ok = 32'(cur.way_sel) < WAY_COUNT;
    sel = RANK_BITS'(cur.way_sel);
    unique case (cur.mode)
      MODE_PROBE: begin
        for (int j = WAY_COUNT - 1; j >= 0; j--) begin
          if (ent[j].valid && ent[j].tag == tag) begin
            found = 1'b1;
            pway = RANK_BITS'(j);
          end
        end
        res.hit = found;
        res.way_out = found ? 2'(pway) : 2'd0;
      end
      MODE_TOUCH: begin
        do_promote = way_ok;
        pway = sel;
        r = ent[sel].rank;
      end
      MODE_WRITE_HIT: begin
        if (way_ok && ent[sel].valid && ent[sel].tag == tag) begin
          do_promote = 1'b1;
          res.hit = 1'b1;
        end
        pway = sel;
        r = ent[sel].rank;
      end
      MODE_INSTALL: begin
        for (int j = WAY_COUNT - 1; j >= 0; j--) begin
          if (!ent[j].valid) begin
            have_inv = 1'b1;
            pway = RANK_BITS'(j);
          end
        end
        for (int j = 1; j < WAY_COUNT; j++) begin
          if (ent[j].rank > ent[best].rank) begin
            best = RANK_BITS'(j);
          end
        end
        if (!have_inv) begin
          pway = best;
        end
        res.way_out = 2'(pway);
        res.replaced = ent[pway].valid;
        nent[pway].valid = 1'b1;
        nent[pway].tag = tag;
        do_promote = 1'b1;
        r = RANK_OLD;
      end
      MODE_EVICT: begin
        if (way_ok && ent[sel].valid) begin
          res.evicted = 1'b1;
          res.evicted_address = {ent[sel].tag, set_idx, OFFSET_BITS'(0)};
          nent[sel].valid = 1'b0;
          nent[sel].rank = RANK_OLD;
          for (int j = 0; j < WAY_COUNT; j++) begin
            if (ent[j].valid && ent[j].rank > ent[sel].rank) begin
              nent[j].rank = ent[j].rank - 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    // Promotion: valid ways ranked below move up, promoted way becomes rank 0.
    if (do_promote) begin
      for (int j = 0; j < WAY_COUNT; j++) begin
        if (RANK_BITS'(j) != pway && ent[j].valid && ent[j].rank < r) begin
          nent[j].rank = ent[j].rank + 1'b1;
        end
      end
      nent[pway].rank = '0;
    end
    for (int j = 0; j < WAY_COUNT; j++) begin
      row_new[j*ENTRY_BITS +: ENTRY_BITS] = nent[j];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.compute) begin
      rsp <= res;
    end
  end
endmodule

/* src/satl_ctrl.sv */
// Controller: clearing pass, request sequencing and output handshake.
module satl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output satl_pkg::ctl_t ctl
);
  import satl_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;
  state_t state;
  logic [INDEX_BITS-1:0] cnt;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign ctl.capture = in_valid && in_ready;
  assign ctl.read = ctl.capture;
  assign ctl.compute = (state == S_EXEC);
  assign ctl.clear = (state == S_CLEAR);
  assign ctl.clear_index = cnt;

  // State, clear counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == INDEX_BITS'(SET_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (ctl.capture) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/set_assoc_tag_store_lru.sv */
// Top level of the set-associative tag store with true LRU.
//   channel | signals                    | direction
//   request | in_valid, in_ready, in_data | in
//   result  | out_valid, out_ready, out_data | out
// Each transaction is one set read from the row memory, then the compute and
// write-back of the row, which also loads the result register.
// A new request is taken no earlier than the cycle in which the previous result is taken.
// After reset a clearing pass writes one set a cycle until all SET_COUNT (64) sets are cleared.
// A stalled result holds until out_ready.
module set_assoc_tag_store_lru (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  satl_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output satl_pkg::rsp_t out_data
);
  import satl_pkg::*;

  ctl_t ctl;

  satl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .ctl(ctl)
  );

  satl_datapath u_dp (.clk(clk), .ctl(ctl), .req(in_data), .rsp(out_data));
endmodule

/* src/satl_checker.sv */
// Port checker for the tag store, bound to the top level.
module satl_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input satl_pkg::rsp_t out_data,
  input logic           out_valid,
  input logic           out_ready
);
  import satl_pkg::*;

  // An accepted request yields a result, raised by out_valid after the execute state.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 out_valid) else $error("result missing");
  // No request is taken while an untaken result is pending.
  a_block: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("accept under stall");
  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed");
  // Hit and eviction never come together.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.evicted)) else $error("hit and evict");
endmodule

bind set_assoc_tag_store_lru satl_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);

/* tb/tb_set_assoc_tag_store_lru.sv */
// Testbench of the set-associative tag store: random requests checked against a tag/LRU model.
`timescale 1ns / 1ps

module tb;
  import satl_pkg::*;

  localparam int NUM_ITEMS = 600;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  int err_count;
  int sent_count;
  bit stim_done;
  bit hold_off;

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Model of the tag array and the LRU ranks.
  class lru_scoreboard;
    bit valid_q[SET_COUNT][WAY_COUNT];
    logic [TAG_BITS-1:0] tag_q[SET_COUNT][WAY_COUNT];
    int rank_q[SET_COUNT][WAY_COUNT];
    rsp_t pending[$];

    function new();
      for (int s = 0; s < SET_COUNT; s++) begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          valid_q[s][w] = 0;
          tag_q[s][w] = '0;
          rank_q[s][w] = WAY_COUNT - 1;
        end
      end
    endfunction

    function void promote(int s, int w);
      int r;
      r = rank_q[s][w];
      for (int j = 0; j < WAY_COUNT; j++) begin
        if (j != w && valid_q[s][j] && rank_q[s][j] < r) rank_q[s][j]++;
      end
      rank_q[s][w] = 0;
    endfunction

    // Note an accepted request and queue the result it should produce.
    function void note_request(req_t rq);
      rsp_t rs;
      int s;
      int w;
      int v;
      int r;
      logic [TAG_BITS-1:0] tg;
      rs = '0;
      s = int'(rq.address[OFFSET_BITS +: INDEX_BITS]);
      tg = rq.address[31 -: TAG_BITS];
      w = int'(rq.way_sel);
      case (rq.mode)
        MODE_PROBE: begin
          for (int j = WAY_COUNT - 1; j >= 0; j--) begin
            if (valid_q[s][j] && tag_q[s][j] == tg) begin
              rs.hit = 1;
              rs.way_out = 2'(j);
            end
          end
        end
        MODE_TOUCH: if (w < WAY_COUNT) promote(s, w);
        MODE_WRITE_HIT: begin
          if (w < WAY_COUNT && valid_q[s][w] && tag_q[s][w] == tg) begin
            promote(s, w);
            rs.hit = 1;
          end
        end
        MODE_INSTALL: begin
          v = -1;
          for (int j = 0; j < WAY_COUNT; j++) begin
            if (v < 0 && !valid_q[s][j]) v = j;
          end
          if (v < 0) begin
            v = 0;
            for (int j = 1; j < WAY_COUNT; j++) begin
              if (rank_q[s][j] > rank_q[s][v]) v = j;
            end
          end
          rs.way_out = 2'(v);
          rs.replaced = valid_q[s][v];
          valid_q[s][v] = 1;
          tag_q[s][v] = tg;
          rank_q[s][v] = WAY_COUNT - 1;
          promote(s, v);
        end
        MODE_EVICT: begin
          if (w < WAY_COUNT && valid_q[s][w]) begin
            r = rank_q[s][w];
            rs.evicted = 1;
            rs.evicted_address = {tag_q[s][w], INDEX_BITS'(s), OFFSET_BITS'(0)};
            valid_q[s][w] = 0;
            rank_q[s][w] = WAY_COUNT - 1;
            for (int j = 0; j < WAY_COUNT; j++) begin
              if (valid_q[s][j] && rank_q[s][j] > r) rank_q[s][j]--;
            end
          end
        end
        default: ;
      endcase
      pending.push_back(rs);
    endfunction

    // Compare one accepted result with the oldest expectation.
    task check_result(rsp_t got);
      rsp_t exp;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) report($sformatf("hit %b, want %b", got.hit, exp.hit));
      if (got.way_out !== exp.way_out)
        report($sformatf("way_out %0d, want %0d", got.way_out, exp.way_out));
      if (got.replaced !== exp.replaced)
        report($sformatf("replaced %b, want %b", got.replaced, exp.replaced));
      if (got.evicted !== exp.evicted)
        report($sformatf("evicted %b, want %b", got.evicted, exp.evicted));
      if (got.evicted_address !== exp.evicted_address)
        report($sformatf("evicted_address %h, want %h", got.evicted_address,
                         exp.evicted_address));
    endtask
  endclass

  lru_scoreboard lru_model;

  set_assoc_tag_store_lru u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Few tags and sets so that hits and full sets are common.
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(0, 9) != 0) begin
      a[OFFSET_BITS +: INDEX_BITS] = INDEX_BITS'($urandom_range(0, 3));
      a[31 -: TAG_BITS] = TAG_BITS'($urandom_range(0, 6));
    end
    return a;
  endfunction

  // Offer one request and wait for its transaction.
  task automatic send_req(logic [2:0] md, logic [31:0] addr, logic [1:0] way);
    req_t rq;
    rq.mode = md;
    rq.address = addr;
    rq.way_sel = way;
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
    lru_model.note_request(rq);
    sent_count++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Request driver: directed items, then random ones.
  initial begin
    logic [2:0] md;
    in_valid = 0;
    in_data = '0;
    rst = 1;
    err_count = 0;
    sent_count = 0;
    stim_done = 0;
    lru_model = new();
    repeat (5) @(posedge clk);
    rst <= 0;
    send_req(MODE_PROBE, 32'h0000_0000, 2'd0);
    send_req(MODE_EVICT, 32'h0000_0000, 2'd0);
    send_req(MODE_INSTALL, 32'h0000_0000, 2'd0);
    send_req(MODE_INSTALL, 32'hFFFF_FFFF, 2'd3);
    send_req(MODE_INSTALL, 32'h1000_0000, 2'd1);
    send_req(MODE_INSTALL, 32'h2000_0000, 2'd2);
    send_req(MODE_INSTALL, 32'h3000_0000, 2'd3);
    send_req(MODE_INSTALL, 32'h4000_0000, 2'd0);
    send_req(MODE_PROBE, 32'h2000_0000, 2'd0);
    send_req(MODE_PROBE, 32'hFFFF_FFFF, 2'd3);
    send_req(MODE_TOUCH, 32'h0000_0000, 2'd3);
    send_req(MODE_TOUCH, 32'h0000_0000, 2'd0);
    send_req(MODE_WRITE_HIT, 32'h2000_0000, 2'd2);
    send_req(MODE_WRITE_HIT, 32'h2000_0000, 2'd1);
    send_req(MODE_INSTALL, 32'h5000_0000, 2'd0);
    send_req(MODE_EVICT, 32'h0000_0000, 2'd1);
    send_req(MODE_EVICT, 32'hFFFF_FFFF, 2'd3);
    send_req(3'd5, 32'hFFFF_FFFF, 2'd3);
    send_req(3'd7, 32'h0000_0000, 2'd0);
    send_req(MODE_INSTALL, 32'h0000_0000, 2'd1);
    for (int i = 0; i < NUM_ITEMS; i++) begin
      idle_gap(gap_len());
      case ($urandom_range(0, 15))
        0, 1, 2: md = MODE_PROBE;
        3, 4: md = MODE_TOUCH;
        5, 6: md = MODE_WRITE_HIT;
        7, 8, 9, 10, 11: md = MODE_INSTALL;
        12, 13, 14: md = MODE_EVICT;
        default: md = 3'($urandom_range(5, 7));
      endcase
      send_req(md, pick_address(), 2'($urandom_range(0, 3)));
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Result side: random stalls, one long hold-off early in the run.
  initial begin
    out_ready = 0;
    hold_off = 0;
    @(negedge rst);
    while (!stim_done || lru_model.pending.size() != 0) begin
      if (sent_count > 40 && !hold_off) begin
        hold_off = 1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) lru_model.check_result(out_data);
  end

  // Watchdog on cycles without any transaction, and the end of the run.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(negedge rst);
    while (!(stim_done && lru_model.pending.size() == 0)) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
src/satl_pkg.sv
src/satl_ram.sv
src/satl_datapath.sv
src/satl_ctrl.sv
src/set_assoc_tag_store_lru.sv
src/satl_checker.sv
tb/tb_set_assoc_tag_store_lru.sv
